// ===== src/cpe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Cologne phonetic encoder.
// No dependencies; imported by every module of the block.
package cpe_pkg;

    localparam logic [3:0] SYM_H    = 4'd10;  // separator symbol for h
    localparam logic [3:0] SYM_NONE = 4'd15;  // no symbol seen yet
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    // One result beat as it leaves the block
    typedef struct packed {
        logic [3:0] digit;
        logic       valid;
        logic       last;
    } t_result;

    // Results caused by one accepted byte; num holds the count minus one
    typedef struct packed {
        t_result [3:0] res;
        logic [1:0]    num;
    } t_entry;

endpackage

// ===== src/cpe_front.sv =====
`timescale 1ns / 1ps
// Front end: holds the byte window, codes bytes and filters repeats.
// Depends on cpe_pkg; pushes one t_entry per byte that causes results.
module cpe_front
    import cpe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output logic       o_push,
    output t_entry     o_entry
);

    typedef struct packed {
        logic [1:0] n;
        logic [3:0] s0;
        logic [3:0] s1;
    } t_syms;

    function automatic t_syms classify(input logic [7:0] p, input logic [7:0] c,
                                       input logic [7:0] n, input logic first);
        t_syms r;
        r = '{n: 2'd1, s0: 4'd0, s1: 4'd0};
        if (first && c == "c") begin
            r.s0 = (n == "a" || n == "h" || n == "k" || n == "l" || n == "o" ||
                    n == "q" || n == "r" || n == "u" || n == "x") ? 4'd4 : 4'd8;
        end else if (c == "p" && n == "h") begin
            r.s0 = 4'd3;
        end else if (c == "d" || c == "t") begin
            r.s0 = (n == "s" || n == "c" || n == "z") ? 4'd8 : 4'd2;
        end else if (c == "x") begin
            if (p == "c" || p == "k" || p == "q") begin
                r.s0 = 4'd8;
            end else begin
                r.n  = 2'd2;
                r.s0 = 4'd4;
                r.s1 = 4'd8;
            end
        end else if (c == "c") begin
            if (p == "s" || p == "z") r.s0 = 4'd8;
            else r.s0 = (n == "a" || n == "o" || n == "u" || n == "h" || n == "k" ||
                         n == "x" || n == "q") ? 4'd4 : 4'd8;
        end else if (c == "h") begin
            r.s0 = SYM_H;
        end else if (c == "a" || c == "e" || c == "i" || c == "j" || c == "o" ||
                     c == "u" || c == "y") begin
            r.s0 = 4'd0;
        end else if (c == "b" || c == "p") begin
            r.s0 = 4'd1;
        end else if (c == "f" || c == "v" || c == "w") begin
            r.s0 = 4'd3;
        end else if (c == "g" || c == "k" || c == "q") begin
            r.s0 = 4'd4;
        end else if (c == "l") begin
            r.s0 = 4'd5;
        end else if (c == "r") begin
            r.s0 = 4'd7;
        end else if (c == "m" || c == "n") begin
            r.s0 = 4'd6;
        end else if (c == "s" || c == "z") begin
            r.s0 = 4'd8;
        end else begin
            r.n = 2'd0;
        end
        return r;
    endfunction

    logic [7:0] r_prev, n_prev;
    logic [7:0] r_cur;
    logic       r_hold, n_hold;
    logic       r_first, n_first;
    logic [3:0] r_last_sym, n_last_sym;
    logic       r_seen, n_seen;

    t_syms      w_a, w_b;
    logic       w_first_b;
    logic [7:0] w_prev_b;
    t_entry     w_entry;
    logic [2:0] w_cnt;

    always_comb begin
        logic [3:0] ls;
        logic       sn;
        logic [3:0] s;
        logic       en;
        logic [1:0] nn;
        ls = r_last_sym;
        sn = r_seen;
        s  = 4'd0;
        en = 1'b0;
        nn = 2'd0;
        w_cnt     = 3'd0;
        w_entry   = '0;
        w_first_b = r_hold ? 1'b0 : r_first;
        w_prev_b  = r_hold ? r_cur : r_prev;
        w_a = classify(r_prev, r_cur, i_ch, r_first);
        w_b = classify(w_prev_b, i_ch, CH_SPACE, w_first_b);
        // held byte first, then the final byte when the word ends here
        for (int b = 0; b < 2; b++) begin
            for (int j = 0; j < 2; j++) begin
                en = (b == 0) ? r_hold : i_last;
                nn = (b == 0) ? w_a.n : w_b.n;
                if (b == 0) s = (j == 0) ? w_a.s0 : w_a.s1;
                else        s = (j == 0) ? w_b.s0 : w_b.s1;
                if (en && (2'(j) < nn) && s != ls) begin
                    ls = s;
                    if (s != SYM_H && !(s == 4'd0 && sn)) begin
                        sn = 1'b1;
                        w_entry.res[w_cnt[1:0]] = '{digit: s, valid: 1'b1, last: 1'b0};
                        w_cnt = w_cnt + 3'd1;
                    end
                end
            end
        end
        if (i_last) begin
            if (w_cnt == 3'd0) begin
                w_entry.res[0] = '{digit: 4'd0, valid: 1'b0, last: 1'b1};
                w_cnt = 3'd1;
            end else begin
                w_entry.res[2'(w_cnt - 3'd1)].last = 1'b1;
            end
        end
        w_entry.num = 2'(w_cnt - 3'd1);

        if (i_last) begin
            n_prev     = CH_SPACE;
            n_hold     = 1'b0;
            n_first    = 1'b1;
            n_last_sym = SYM_NONE;
            n_seen     = 1'b0;
        end else begin
            n_prev     = w_prev_b;
            n_hold     = 1'b1;
            n_first    = w_first_b;
            n_last_sym = ls;
            n_seen     = sn;
        end
    end

    assign o_push  = i_accept && (w_cnt != 3'd0);
    assign o_entry = w_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= CH_SPACE;
            r_hold     <= 1'b0;
            r_first    <= 1'b1;
            r_last_sym <= SYM_NONE;
            r_seen     <= 1'b0;
        end else if (i_accept) begin
            r_prev     <= n_prev;
            r_hold     <= n_hold;
            r_first    <= n_first;
            r_last_sym <= n_last_sym;
            r_seen     <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) r_cur <= i_ch;
    end

endmodule

// ===== src/cpe_queue.sv =====
`timescale 1ns / 1ps
// Short queue of result entries between front and back end.
// Depends on cpe_pkg for t_entry and the queue depth.
module cpe_queue
    import cpe_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_head
);

    t_entry           r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == QAW'(QDEPTH - 1)) ? '0 : r_wp + QAW'(1);
            if (i_pop)  r_rp <= (r_rp == QAW'(QDEPTH - 1)) ? '0 : r_rp + QAW'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + (QAW+1)'(1);
            else if (!i_push && i_pop) r_cnt <= r_cnt - (QAW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_entry;
    end

endmodule

// ===== src/cpe_back.sv =====
`timescale 1ns / 1ps
// Back end: walks through queued entries and sends one result per beat.
// Depends on cpe_pkg; owns the output register of the master side.
module cpe_back
    import cpe_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_empty,
    input  t_entry i_head,
    output logic   o_pop,
    output logic   o_valid,
    input  logic   i_ready,
    output t_result o_res
);

    logic       r_busy;
    t_entry     r_ent;
    logic [1:0] r_idx;
    logic       r_ov;
    t_result    r_out;

    logic w_free, w_load, w_done;

    assign w_free = !r_ov || i_ready;
    assign w_load = r_busy && w_free;
    assign w_done = (r_idx == r_ent.num);
    assign o_pop  = !i_empty && (!r_busy || (w_load && w_done));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
            r_idx  <= 2'd0;
        end else begin
            if (w_free) r_ov <= r_busy;
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= 2'd0;
            end else if (w_load) begin
                if (w_done) r_busy <= 1'b0;
                else        r_idx  <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop)  r_ent <= i_head;
        if (w_load) r_out <= r_ent.res[r_idx];
    end

    assign o_valid = r_ov;
    assign o_res   = r_out;

endmodule

// ===== src/cologne_phonetic_encoder.sv =====
`timescale 1ns / 1ps
// Cologne phonetic encoder, top level: front end, entry queue and back end.
// Depends on cpe_pkg, cpe_front, cpe_queue and cpe_back.
//
// Feed a lower-case word one byte per beat on the slave side, with tlast on
// its final byte; the code digits come out one per beat on the master side,
// tlast marking the word's last result. A word end that yields no digit gives
// one beat with tuser low (no digit) and tlast high. A byte is coded once its
// follower has arrived, so results of a byte appear with the next beat or at
// the word end. A byte is taken every cycle while the two-entry queue has
// room; the back end sends one result per cycle while the receiver is
// ready, so a byte with several results slows the input; an x at a word
// end can cause up to four. From an empty queue, an entry passes the back
// end's entry and output registers before its first result beat.
module cologne_phonetic_encoder
    import cpe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // slave side: one byte of the word per beat
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,    // [7:0] ch
    input  logic       i_s_tlast,    // last_of_word
    // master side: one code result per beat
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,    // [3:0] code_digit, [7:4] zero
    output logic       o_m_tuser,    // digit_valid
    output logic       o_m_tlast     // word_end
);

    logic    w_accept;
    logic    w_push, w_pop, w_full, w_empty;
    t_entry  w_entry, w_head;
    t_result w_res;

    // Taking a byte only needs room in the queue for its entry
    assign o_s_tready = !w_full;
    assign w_accept   = i_s_tvalid && o_s_tready;

    cpe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_ch     (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_push   (w_push),
        .o_entry  (w_entry)
    );

    cpe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    cpe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (w_res)
    );

    assign o_m_tdata = {4'd0, w_res.digit};
    assign o_m_tuser = w_res.valid;
    assign o_m_tlast = w_res.last;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for cologne_phonetic_encoder: directed words, then random words.
// Depends on cpe_pkg and the encoder RTL; every result beat is checked against a local model or typed expectations.
module tb_top
    import cpe_pkg::*;
();

    localparam int RAND_BYTES  = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;   // long receiver hold-off, fills the entry queue
    localparam int DRAIN_WAIT  = 16;    // linger after the expected results have drained

    // how a row's expectation is formed
    localparam logic [1:0] EXP_MODEL = 2'd0;  // from the word model
    localparam logic [1:0] EXP_ONE   = 2'd1;  // one typed result
    localparam logic [1:0] EXP_TWO   = 2'd2;  // two typed digits

    typedef struct packed {
        logic [7:0] ch;
        logic       eow;
        logic [1:0] typed;
        logic [3:0] d0;
        logic       v0;
        logic [3:0] d1;
    } t_dir_row;

    localparam int DIR_ROWS = 25;
    localparam t_dir_row DIR_TAB [0:DIR_ROWS-1] = '{
        // one-byte words: results readable at a glance
        '{8'h00, 1'b1, EXP_ONE, 4'd0, 1'b0, 4'd0},   // zero byte: empty-word marker
        '{8'hff, 1'b1, EXP_ONE, 4'd0, 1'b0, 4'd0},   // all ones: empty-word marker
        '{"a",   1'b1, EXP_ONE, 4'd0, 1'b1, 4'd0},   // vowel as first code keeps its 0
        '{"x",   1'b1, EXP_TWO, 4'd4, 1'b1, 4'd8},   // lone x gives 4 then 8
        '{"h",   1'b1, EXP_ONE, 4'd0, 1'b0, 4'd0},   // separator only: marker
        '{"s",   1'b1, EXP_ONE, 4'd8, 1'b1, 4'd0},
        // "phdsxkx": ph, d before s, x after k
        '{"p", 1'b0, EXP_MODEL, 4'd0, 1'b0, 4'd0},
        '{"h", 1'b0, EXP_MODEL, 4'd0, 1'b0, 4'd0},
        '{"d", 1'b0, EXP_MODEL, 4'd0, 1'b0, 4'd0},
        '{"s", 1'b0, EXP_MODEL, 4'd0, 1'b0, 4'd0},
        '{"x", 1'b0, EXP_MODEL, 4'd0, 1'b0, 4'd0},
        '{"k", 1'b0, EXP_MODEL, 4'd0, 1'b0, 4'd0},
        '{"x", 1'b1, EXP_MODEL, 4'd0, 1'b0, 4'd0},
        // "coz cy": initial c, late vowel dropped, space inside the word, c after space
        '{"c", 1'b0, EXP_MODEL, 4'd0, 1'b0, 4'd0},
        '{"o", 1'b0, EXP_MODEL, 4'd0, 1'b0, 4'd0},
        '{"z", 1'b0, EXP_MODEL, 4'd0, 1'b0, 4'd0},
        '{" ", 1'b0, EXP_MODEL, 4'd0, 1'b0, 4'd0},
        '{"c", 1'b0, EXP_MODEL, 4'd0, 1'b0, 4'd0},
        '{"y", 1'b1, EXP_MODEL, 4'd0, 1'b0, 4'd0},
        // "mlrbxx": the final x brings four results on one beat
        '{"m", 1'b0, EXP_MODEL, 4'd0, 1'b0, 4'd0},
        '{"l", 1'b0, EXP_MODEL, 4'd0, 1'b0, 4'd0},
        '{"r", 1'b0, EXP_MODEL, 4'd0, 1'b0, 4'd0},
        '{"b", 1'b0, EXP_MODEL, 4'd0, 1'b0, 4'd0},
        '{"x", 1'b0, EXP_MODEL, 4'd0, 1'b0, 4'd0},
        '{"x", 1'b1, EXP_MODEL, 4'd0, 1'b0, 4'd0}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata = 8'h00;    // [7:0] ch
    logic       i_s_tlast = 1'b0;     // last_of_word
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;            // [3:0] code_digit, [7:4] zero
    logic       o_m_tuser;            // digit_valid
    logic       o_m_tlast;            // word_end

    cologne_phonetic_encoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Word model: three-byte window, symbol collapse, leading-0 rule
    // ---------------------------------------------------------------------
    logic [7:0] win_prev, win_cur;
    logic       win_full;        // win_cur holds a byte awaiting its follower
    logic       first_pending;   // next byte coded is the word's first
    logic [3:0] prev_sym;        // last symbol incl. separator; SYM_NONE at word start
    logic       digit_out;       // a digit of this word has gone out
    t_result    step_res[$];     // results of the current beat
    t_result    code_q[$];       // code results still owed by the block

    function automatic void clear_word();
        win_prev      = CH_SPACE;
        win_cur       = 8'h00;
        win_full      = 1'b0;
        first_pending = 1'b1;
        prev_sym      = SYM_NONE;
        digit_out     = 1'b0;
    endfunction

    // symbols of byte c between neighbours p and n; returns how many (0..2)
    function automatic int byte_syms(input logic [7:0] p, input logic [7:0] c,
                                     input logic [7:0] n, input logic first,
                                     output logic [3:0] s0, output logic [3:0] s1);
        s0 = 4'd0;
        s1 = 4'd0;
        if (first && c == "c") begin
            s0 = (n inside {"a", "h", "k", "l", "o", "q", "r", "u", "x"}) ? 4'd4 : 4'd8;
            return 1;
        end
        if (c == "p" && n == "h") begin
            s0 = 4'd3;
            return 1;
        end
        if (c inside {"d", "t"}) begin
            s0 = (n inside {"s", "c", "z"}) ? 4'd8 : 4'd2;
            return 1;
        end
        if (c == "x") begin
            if (p inside {"c", "k", "q"}) begin
                s0 = 4'd8;
                return 1;
            end
            s0 = 4'd4;
            s1 = 4'd8;
            return 2;
        end
        if (c == "c") begin
            if (p inside {"s", "z"}) s0 = 4'd8;
            else s0 = (n inside {"a", "o", "u", "h", "k", "x", "q"}) ? 4'd4 : 4'd8;
            return 1;
        end
        if (c == "h") begin
            s0 = SYM_H;
            return 1;
        end
        if (c inside {"a", "e", "i", "j", "o", "u", "y"}) begin s0 = 4'd0; return 1; end
        if (c inside {"b", "p"})      begin s0 = 4'd1; return 1; end
        if (c inside {"f", "v", "w"}) begin s0 = 4'd3; return 1; end
        if (c inside {"g", "k", "q"}) begin s0 = 4'd4; return 1; end
        if (c == "l")                 begin s0 = 4'd5; return 1; end
        if (c == "r")                 begin s0 = 4'd7; return 1; end
        if (c inside {"m", "n"})      begin s0 = 4'd6; return 1; end
        if (c inside {"s", "z"})      begin s0 = 4'd8; return 1; end
        return 0;
    endfunction

    function automatic void take_sym(input logic [3:0] s);
        if (s == prev_sym) return;
        prev_sym = s;
        if (s == SYM_H) return;
        if (s == 4'd0 && digit_out) return;
        digit_out = 1'b1;
        step_res.push_back('{digit: s, valid: 1'b1, last: 1'b0});
    endfunction

    function automatic void code_held(input logic [7:0] p, input logic [7:0] c,
                                      input logic [7:0] n);
        int         k;
        logic [3:0] s0, s1;
        k = byte_syms(p, c, n, first_pending, s0, s1);
        first_pending = 1'b0;
        if (k > 0) take_sym(s0);
        if (k > 1) take_sym(s1);
    endfunction

    function automatic void predict_beat(input logic [7:0] ch, input logic eow);
        step_res.delete();
        if (win_full) begin
            code_held(win_prev, win_cur, ch);
            win_prev = win_cur;
        end
        win_cur  = ch;
        win_full = 1'b1;
        if (eow) begin
            code_held(win_prev, win_cur, CH_SPACE);
            if (step_res.size() == 0)
                step_res.push_back('{digit: 4'd0, valid: 1'b0, last: 1'b0});
            step_res[step_res.size() - 1].last = 1'b1;
            clear_word();
        end
    endfunction

    // ---------------------------------------------------------------------
    // Shared run state
    // ---------------------------------------------------------------------
    int errors      = 0;
    int cycles      = 0;
    int words_sent  = 0;
    int bytes_sent  = 0;
    int digits_seen = 0;
    int marks_seen  = 0;
    int quad_beats  = 0;   // input beats owing four results
    int hold_asked  = 0;   // bumped by the sender to request a long hold-off
    bit calm        = 1'b0; // no idling on either side

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("MISMATCH cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, code_q.size());
            $display("cologne_phonetic_encoder test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Result side: checks each beat, random back-pressure, long hold-off
    // ---------------------------------------------------------------------
    int      hold_seen = 0;
    int      hold_left = 0;
    t_result want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (code_q.size() == 0) begin
                report_mismatch("result beat with nothing pending, tdata", o_m_tdata, -1);
            end else begin
                want = code_q.pop_front();
                if (o_m_tdata !== {4'd0, want.digit})
                    report_mismatch("tdata (code digit)", o_m_tdata, want.digit);
                if (o_m_tuser !== want.valid)
                    report_mismatch("tuser (digit valid)", o_m_tuser, want.valid);
                if (o_m_tlast !== want.last)
                    report_mismatch("tlast (word end)", o_m_tlast, want.last);
                if (want.valid) digits_seen++;
                else marks_seen++;
            end
        end
        if (hold_asked != hold_seen) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= calm || ($urandom_range(99) >= 33);
        end
    end

    // ---------------------------------------------------------------------
    // Byte side
    // ---------------------------------------------------------------------
    // Offers one byte, waits for the beat, then books what it owes.
    task automatic send_byte(input logic [7:0] ch, input logic eow, input logic [1:0] typed,
                             input logic [3:0] d0, input logic v0, input logic [3:0] d1);
        while (!calm && $urandom_range(99) < 33) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= ch;
        i_s_tlast  <= eow;
        do @(posedge i_clk); while (!o_s_tready);
        predict_beat(ch, eow);
        if (step_res.size() == 4) quad_beats++;
        case (typed)
            EXP_ONE: begin
                code_q.push_back('{digit: d0, valid: v0, last: 1'b1});
            end
            EXP_TWO: begin
                code_q.push_back('{digit: d0, valid: 1'b1, last: 1'b0});
                code_q.push_back('{digit: d1, valid: 1'b1, last: 1'b1});
            end
            default: begin
                foreach (step_res[i]) code_q.push_back(step_res[i]);
            end
        endcase
        bytes_sent++;
        if (eow) words_sent++;
    endtask

    // Mostly letters, weighted towards the context-sensitive ones; some noise.
    function automatic logic [7:0] pick_byte();
        string tricky;
        int    r;
        tricky = "cxhpdtszkqcx";
        r = $urandom_range(99);
        if (r < 45) return tricky[$urandom_range(tricky.len() - 1)];
        if (r < 80) return 8'h61 + 8'($urandom_range(25));
        if (r < 90) return $urandom_range(1) ? CH_SPACE : 8'h41 + 8'($urandom_range(25));
        return 8'($urandom_range(255));
    endfunction

    initial begin
        int         rnd_bytes;
        int         wlen;
        logic [7:0] ch;

        clear_word();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words
        for (int r = 0; r < DIR_ROWS; r++)
            send_byte(DIR_TAB[r].ch, DIR_TAB[r].eow, DIR_TAB[r].typed,
                      DIR_TAB[r].d0, DIR_TAB[r].v0, DIR_TAB[r].d1);

        // random words; calm stretch, one drain pause and one long hold-off on the way
        rnd_bytes = 0;
        while (rnd_bytes < RAND_BYTES) begin
            wlen = ($urandom_range(9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 6);
            for (int i = 0; i < wlen; i++) begin
                calm = (rnd_bytes >= 100 && rnd_bytes < 200);
                if (rnd_bytes == 60) begin
                    // sender stands still until the block has delivered everything
                    i_s_tvalid <= 1'b0;
                    do @(posedge i_clk); while (code_q.size() != 0);
                end
                if (rnd_bytes == 230) hold_asked++;
                ch = pick_byte();
                send_byte(ch, i == wlen - 1, EXP_MODEL, 4'd0, 1'b0, 4'd0);
                rnd_bytes++;
            end
        end
        calm = 1'b0;
        i_s_tvalid <= 1'b0;

        // drain, then linger in case anything stray follows
        while (code_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d bytes in %0d words, incl. noise bytes, stalls and a forced queue fill;",
                 bytes_sent, words_sent);
        $display("%0d code digits and %0d empty-word markers checked, %0d four-result beats",
                 digits_seen, marks_seen, quad_beats);
        if (errors == 0) begin
            $display("cologne_phonetic_encoder test passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("cologne_phonetic_encoder test failed");
        end
        $finish;
    end

endmodule

// ===== cologne_phonetic_encoder.f =====
src/cpe_pkg.sv
src/cpe_front.sv
src/cpe_queue.sv
src/cpe_back.sv
src/cologne_phonetic_encoder.sv
test/tb_top.sv
